>>> design/stack_bytecode_executor_macros.svh
// Assertion macros shared by the stack bytecode executor checker
`ifndef STACK_BYTECODE_EXECUTOR_MACROS_SVH
`define STACK_BYTECODE_EXECUTOR_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while in reset
`define SBE_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while in reset
`define SBE_ASSERT_NXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> design/sbe_pkg.sv
// Shared constants, opcodes, fault codes and types of the stack bytecode executor
package sbe_pkg;

	localparam int STACK_DEPTH = 256;
	localparam int VAR_COUNT   = 64;
	localparam int SADDR_W     = $clog2(STACK_DEPTH);
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int VIDX_W      = $clog2(VAR_COUNT);

	localparam logic [4:0] OP_LDI      = 5'd0;
	localparam logic [4:0] OP_PUSH_STR = 5'd1;
	localparam logic [4:0] OP_ADD      = 5'd2;
	localparam logic [4:0] OP_SUB      = 5'd3;
	localparam logic [4:0] OP_MUL      = 5'd4;
	localparam logic [4:0] OP_DIV      = 5'd5;
	localparam logic [4:0] OP_NEG      = 5'd6;
	localparam logic [4:0] OP_EQ       = 5'd7;
	localparam logic [4:0] OP_NE       = 5'd8;
	localparam logic [4:0] OP_GT       = 5'd9;
	localparam logic [4:0] OP_GE       = 5'd10;
	localparam logic [4:0] OP_LT       = 5'd11;
	localparam logic [4:0] OP_LE       = 5'd12;
	localparam logic [4:0] OP_LDV      = 5'd13;
	localparam logic [4:0] OP_ASSIGN   = 5'd14;
	localparam logic [4:0] OP_JUMP     = 5'd15;
	localparam logic [4:0] OP_JZ       = 5'd16;
	localparam logic [4:0] OP_CALL     = 5'd17;
	localparam logic [4:0] OP_RET      = 5'd18;
	localparam logic [4:0] OP_EMIT     = 5'd19;

	localparam logic [2:0] F_NONE   = 3'd0;
	localparam logic [2:0] F_UNDER  = 3'd1;
	localparam logic [2:0] F_OVER   = 3'd2;
	localparam logic [2:0] F_DIV0   = 3'd3;
	localparam logic [2:0] F_VAR    = 3'd4;
	localparam logic [2:0] F_OPC    = 3'd5;
	localparam logic [2:0] F_TARGET = 3'd6;

	typedef struct packed {
		logic        str;
		logic [31:0] val;
	} entry_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quotient;
	} div_rsp_t;

endpackage

>>> design/stack_bytecode_executor.sv
// Steps: the accepted word and the stack and variable entries it reads are registered, then the
// execute and write-back step (EXEC) loads the result register; a division waits in DIV on the
// serial divider. A new instruction is taken only once the last one has finished.
// A result that cannot be loaded because the last word still waits holds the input off until that word is taken.
// Reset: asynchronous, active low; clears pc, stack pointer, halt flag, program size and
// the variable valid bits, so every variable reads as integer zero until assigned.
module stack_bytecode_executor import sbe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,     // program_size
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,       // [31:0] operand
	input  logic [4:0]  s_tuser,       // [4:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,       // [15:0] next_pc, [16] halted, [17] print_valid,
	                                   // [49:18] print_value, [52:50] fault, zero above
	output logic        m_tuser        // [0] print_is_string
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_WAIT = 2'd3;

	logic [1:0]      state_q;
	logic [15:0]     psize_q;
	logic [15:0]     pc_q;
	logic [SP_W-1:0] sp_q;
	logic            halt_q;
	logic [4:0]      op_q;
	logic [31:0]     arg_q;

	entry_t stk_mem [STACK_DEPTH];
	entry_t var_mem [VAR_COUNT];
	logic [VAR_COUNT-1:0] var_vld_q;
	entry_t top_q, sec_q, var_rd_q;
	logic   var_rd_vld_q;

	logic [SP_W-1:0] sp_m1, sp_m2;
	logic            accept;

	div_req_t div_req;
	div_rsp_t div_rsp;

	// Execute stage results
	logic              skip, div_go, fire, do_upd, ovr;
	logic [2:0]        fault;
	logic              wr_en, vwr_en;
	logic [SP_W-1:0]   wr_ptr, sp_nxt;
	entry_t            wr_data, var_e;
	logic [16:0]       npc;
	logic [15:0]       npc_f;
	logic              pv, ps;
	logic [31:0]       pval, r, a, b, prod;
	logic              res_halt;
	logic [55:0]       res_data;
	logic              res_user;
	logic [55:0]       hold_data_q;
	logic              hold_user_q;
	logic              out_free;
	logic              load_out;

	assign sp_m1    = sp_q - SP_W'(1);
	assign sp_m2    = sp_q - SP_W'(2);
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;
	assign load_out = out_free && (fire || state_q == ST_WAIT);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psize_q <= '0;
		end else if (cfg_we) begin
			psize_q <= cfg_wdata;
		end
	end

	// Stack memory: two read ports, one write port
	always_ff @(posedge clk) begin
		if (accept) begin
			top_q <= stk_mem[sp_m1[SADDR_W-1:0]];
			sec_q <= stk_mem[sp_m2[SADDR_W-1:0]];
		end
		if (fire && do_upd && wr_en) begin
			stk_mem[wr_ptr[SADDR_W-1:0]] <= wr_data;
		end
	end

	// Variable memory with valid bits standing in for the cleared contents
	always_ff @(posedge clk) begin
		if (accept) begin
			var_rd_q <= var_mem[s_tdata[VIDX_W-1:0]];
		end
		if (fire && do_upd && vwr_en) begin
			var_mem[arg_q[VIDX_W-1:0]] <= top_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			var_vld_q    <= '0;
			var_rd_vld_q <= 1'b0;
		end else begin
			if (accept) begin
				var_rd_vld_q <= var_vld_q[s_tdata[VIDX_W-1:0]];
			end
			if (fire && do_upd && vwr_en) begin
				var_vld_q[arg_q[VIDX_W-1:0]] <= 1'b1;
			end
		end
	end

	assign var_e = var_rd_vld_q ? var_rd_q : '0;
	assign a     = sec_q.val;
	assign b     = top_q.val;
	assign prod  = a * b;

	assign div_req.start    = div_go;
	assign div_req.dividend = a;
	assign div_req.divisor  = b;

	sbe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Decode and execute the held instruction against the read entries
	always_comb begin
		logic under1, under2, full, var_bad, tgt_ok, ret_ok;
		under1  = (sp_q == '0);
		under2  = (sp_q < SP_W'(2));
		full    = (sp_q >= SP_W'(STACK_DEPTH));
		var_bad = (arg_q >= 32'(VAR_COUNT));
		tgt_ok  = !arg_q[31] && (arg_q <= {16'd0, psize_q});
		ret_ok  = !b[31] && (b <= {16'd0, psize_q});

		skip    = halt_q || (pc_q >= psize_q);
		fault   = F_NONE;
		div_go  = 1'b0;
		wr_en   = 1'b0;
		vwr_en  = 1'b0;
		wr_ptr  = sp_q;
		wr_data = '0;
		sp_nxt  = sp_q;
		npc     = {1'b0, pc_q} + 17'd1;
		pv      = 1'b0;
		ps      = 1'b0;
		pval    = '0;
		r       = '0;

		if (!skip) begin
			case (op_q)
				OP_LDI, OP_PUSH_STR, OP_LDV: begin
					if (full) begin
						fault = F_OVER;
					end else if (op_q == OP_LDV && var_bad) begin
						fault = F_VAR;
					end else begin
						wr_en   = 1'b1;
						wr_data = (op_q == OP_LDV) ? var_e : {op_q == OP_PUSH_STR, arg_q};
						sp_nxt  = sp_q + SP_W'(1);
						npc     = {1'b0, pc_q} + 17'd2;
					end
				end
				OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_NE, OP_GT, OP_GE, OP_LT,
				OP_LE: begin
					if (under2) begin
						fault = F_UNDER;
					end else begin
						case (op_q)
							OP_ADD: r = a + b;
							OP_SUB: r = a - b;
							OP_MUL: r = prod;
							OP_DIV: begin
								if (b == '0) begin
									fault = F_DIV0;
								end else begin
									div_go = (state_q == ST_EXEC);
									r      = div_rsp.quotient;
								end
							end
							OP_EQ:  r = {31'd0, a == b};
							OP_NE:  r = {31'd0, a != b};
							OP_GT:  r = {31'd0, $signed(a) >  $signed(b)};
							OP_GE:  r = {31'd0, $signed(a) >= $signed(b)};
							OP_LT:  r = {31'd0, $signed(a) <  $signed(b)};
							default: r = {31'd0, $signed(a) <= $signed(b)};
						endcase
						wr_en   = 1'b1;
						wr_ptr  = sp_m2;
						wr_data = {1'b0, r};
						sp_nxt  = sp_m1;
					end
				end
				OP_NEG: begin
					if (under1) begin
						fault = F_UNDER;
					end else begin
						wr_en   = 1'b1;
						wr_ptr  = sp_m1;
						wr_data = {1'b0, 32'd0 - b};
					end
				end
				OP_ASSIGN: begin
					if (under1) begin
						fault = F_UNDER;
					end else if (var_bad) begin
						fault = F_VAR;
					end else begin
						vwr_en = 1'b1;
						sp_nxt = sp_m1;
						npc    = {1'b0, pc_q} + 17'd2;
					end
				end
				OP_JUMP: begin
					if (!tgt_ok) fault = F_TARGET;
					else npc = {1'b0, arg_q[15:0]};
				end
				OP_JZ: begin
					if (under1) begin
						fault = F_UNDER;
					end else if (b == '0) begin
						if (!tgt_ok) begin
							fault = F_TARGET;
						end else begin
							npc    = {1'b0, arg_q[15:0]};
							sp_nxt = sp_m1;
						end
					end else begin
						npc    = {1'b0, pc_q} + 17'd2;
						sp_nxt = sp_m1;
					end
				end
				OP_CALL: begin
					if (full) begin
						fault = F_OVER;
					end else if (!tgt_ok) begin
						fault = F_TARGET;
					end else begin
						wr_en   = 1'b1;
						wr_data = {1'b0, 32'(pc_q) + 32'd2};
						sp_nxt  = sp_q + SP_W'(1);
						npc     = {1'b0, arg_q[15:0]};
					end
				end
				OP_RET: begin
					if (under1) begin
						fault = F_UNDER;
					end else if (!ret_ok) begin
						fault = F_TARGET;
					end else begin
						npc    = {1'b0, b[15:0]};
						sp_nxt = sp_m1;
					end
				end
				OP_EMIT: begin
					if (under1) begin
						fault = F_UNDER;
					end else begin
						pv     = 1'b1;
						pval   = b;
						ps     = top_q.str;
						sp_nxt = sp_m1;
					end
				end
				default: fault = F_OPC;
			endcase
		end

		do_upd   = !skip && (fault == F_NONE);
		ovr      = (npc >= {1'b0, psize_q});
		npc_f    = ovr ? psize_q : npc[15:0];
		res_halt = skip || (fault != F_NONE) || ovr;
		fire     = (state_q == ST_EXEC && !div_go) || (state_q == ST_DIV && div_rsp.done);
		res_data = {3'd0, fault, pval, pv, res_halt, do_upd ? npc_f : pc_q};
		res_user = ps;
	end

	// Sequencer, architectural state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pc_q     <= '0;
			sp_q     <= '0;
			halt_q   <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			// Raise the result word on a load, drop it once taken
			if (load_out) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_EXEC;
				end
				ST_EXEC, ST_DIV: begin
					if (div_go) begin
						state_q <= ST_DIV;
					end else if (fire) begin
						halt_q <= res_halt;
						if (do_upd) begin
							pc_q <= npc_f;
							sp_q <= sp_nxt;
						end
						if (out_free) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_WAIT;
						end
					end
				end
				ST_WAIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= s_tuser;
			arg_q <= s_tdata;
		end
		if (fire) begin
			hold_data_q <= res_data;
			hold_user_q <= res_user;
			if (out_free) begin
				m_tdata <= res_data;
				m_tuser <= res_user;
			end
		end else if (state_q == ST_WAIT && out_free) begin
			m_tdata <= hold_data_q;
			m_tuser <= hold_user_q;
		end
	end

endmodule

>>> design/sbe_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero
module sbe_div import sbe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] mb_q;
	logic        neg_q;
	logic        done_q;
	logic [32:0] trial;

	// Shift in the next dividend bit and try the subtraction
	assign trial = {rem_q, quo_q[31]} - {1'b0, mb_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Load magnitudes, then advance one bit each cycle
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			rem_q <= '0;
			quo_q <= req.dividend[31] ? (32'd0 - req.dividend) : req.dividend;
			mb_q  <= req.divisor[31] ? (32'd0 - req.divisor) : req.divisor;
			neg_q <= req.dividend[31] ^ req.divisor[31];
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? (32'd0 - quo_q) : quo_q;

endmodule

>>> design/sbe_checker.sv
// Port-level checker for the stack bytecode executor, bound to the top level
`include "stack_bytecode_executor_macros.svh"

module sbe_checker import sbe_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic        m_tuser
);

	`SBE_ASSERT_NXT(a_hold_word, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")
	`SBE_ASSERT_NOW(a_fault_halts, m_tvalid && m_tdata[52:50] != F_NONE, m_tdata[16], "fault without halt")
	`SBE_ASSERT_NOW(a_quiet_print, m_tvalid && !m_tdata[17], m_tdata[49:18] == 32'd0 && !m_tuser, "print fields set without print")
	`SBE_ASSERT_NOW(a_print_clean, m_tvalid && m_tdata[17], m_tdata[52:50] == F_NONE && m_tdata[55:53] == 3'd0, "print with a fault or stray pad bits")

endmodule

bind stack_bytecode_executor sbe_checker u_sbe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

>>> test/stack_bytecode_executor_checker.sv
// Checker for the stack bytecode executor: models each instruction and compares every result word
`timescale 1ns / 100ps
module stack_bytecode_executor_checker import sbe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic [4:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,
	input  logic        m_tuser,
	output int          mismatches,
	output int          outstanding
);

	typedef struct packed {
		logic [15:0] next_pc;
		logic        halted;
		logic        printed;
		logic [31:0] print_val;
		logic        print_str;
		logic [2:0]  fault;
	} outcome_t;

	// model state of the machine
	logic [31:0] stack_val [STACK_DEPTH];
	logic        stack_str [STACK_DEPTH];
	logic [31:0] var_val [VAR_COUNT];
	logic        var_str [VAR_COUNT];
	int          depth;
	logic [15:0] pc;
	logic        halt;
	logic [15:0] prog_size;

	outcome_t pending_results [$];

	assign outstanding = pending_results.size();

	function automatic logic target_ok(logic [31:0] t);
		return !t[31] && t <= {16'd0, prog_size};
	endfunction

	// execute one instruction against the model and give the result it should produce
	task automatic run_instruction(input logic [4:0] op, input logic [31:0] arg,
			output outcome_t res);
		logic [31:0] a, b, r, ma, mb, q, npc;
		logic [2:0]  f;
		f   = F_NONE;
		res = '0;
		npc = {16'd0, pc} + 32'd1;
		a   = '0;
		b   = '0;
		r   = '0;
		if (!halt && pc >= prog_size)
			halt = 1'b1;
		if (!halt) begin
			if (op > OP_EMIT) begin
				f = F_OPC;
			end else if (op == OP_LDI || op == OP_PUSH_STR || op == OP_LDV) begin
				if (depth >= STACK_DEPTH)
					f = F_OVER;
				else if (op == OP_LDV && arg >= 32'(VAR_COUNT))
					f = F_VAR;
				else begin
					if (op == OP_LDV) begin
						stack_val[depth] = var_val[arg];
						stack_str[depth] = var_str[arg];
					end else begin
						stack_val[depth] = arg;
						stack_str[depth] = (op == OP_PUSH_STR);
					end
					depth++;
					npc = {16'd0, pc} + 32'd2;
				end
			end else if (op <= OP_LE && op != OP_NEG) begin
				if (depth < 2) begin
					f = F_UNDER;
				end else begin
					a = stack_val[depth - 2];
					b = stack_val[depth - 1];
					case (op)
						OP_ADD: r = a + b;
						OP_SUB: r = a - b;
						OP_MUL: r = a * b;
						OP_DIV: begin
							if (b == 0) begin
								f = F_DIV0;
							end else begin
								ma = a[31] ? -a : a;
								mb = b[31] ? -b : b;
								q  = ma / mb;
								r  = (a[31] != b[31]) ? -q : q;
							end
						end
						OP_EQ: r = {31'd0, a == b};
						OP_NE: r = {31'd0, a != b};
						OP_GT: r = {31'd0, $signed(a) > $signed(b)};
						OP_GE: r = {31'd0, $signed(a) >= $signed(b)};
						OP_LT: r = {31'd0, $signed(a) < $signed(b)};
						default: r = {31'd0, $signed(a) <= $signed(b)};
					endcase
					if (f == F_NONE) begin
						stack_val[depth - 2] = r;
						stack_str[depth - 2] = 1'b0;
						depth--;
					end
				end
			end else if (op == OP_NEG) begin
				if (depth < 1)
					f = F_UNDER;
				else begin
					stack_val[depth - 1] = -stack_val[depth - 1];
					stack_str[depth - 1] = 1'b0;
				end
			end else if (op == OP_ASSIGN) begin
				if (depth < 1)
					f = F_UNDER;
				else if (arg >= 32'(VAR_COUNT))
					f = F_VAR;
				else begin
					var_val[arg] = stack_val[depth - 1];
					var_str[arg] = stack_str[depth - 1];
					depth--;
					npc = {16'd0, pc} + 32'd2;
				end
			end else if (op == OP_JUMP) begin
				if (!target_ok(arg))
					f = F_TARGET;
				else
					npc = arg;
			end else if (op == OP_JZ) begin
				if (depth < 1)
					f = F_UNDER;
				else if (stack_val[depth - 1] == 0) begin
					if (!target_ok(arg))
						f = F_TARGET;
					else begin
						npc = arg;
						depth--;
					end
				end else begin
					npc = {16'd0, pc} + 32'd2;
					depth--;
				end
			end else if (op == OP_CALL) begin
				if (depth >= STACK_DEPTH)
					f = F_OVER;
				else if (!target_ok(arg))
					f = F_TARGET;
				else begin
					stack_val[depth] = {16'd0, pc} + 32'd2;
					stack_str[depth] = 1'b0;
					depth++;
					npc = arg;
				end
			end else if (op == OP_RET) begin
				if (depth < 1)
					f = F_UNDER;
				else if (!target_ok(stack_val[depth - 1]))
					f = F_TARGET;
				else begin
					npc = stack_val[depth - 1];
					depth--;
				end
			end else begin
				if (depth < 1)
					f = F_UNDER;
				else begin
					res.printed   = 1'b1;
					res.print_val = stack_val[depth - 1];
					res.print_str = stack_str[depth - 1];
					depth--;
				end
			end
			if (f != F_NONE) begin
				halt = 1'b1;
			end else begin
				if (npc >= {16'd0, prog_size}) begin
					npc  = {16'd0, prog_size};
					halt = 1'b1;
				end
				pc = npc[15:0];
			end
		end
		res.next_pc = pc;
		res.halted  = halt;
		res.fault   = f;
	endtask

	// compare result words, then model accepted instruction words and register writes
	always @(posedge clk or negedge arst_n) begin : watch
		outcome_t want, got, fresh;
		if (!arst_n) begin
			for (int i = 0; i < VAR_COUNT; i++) begin
				var_val[i] = '0;
				var_str[i] = 1'b0;
			end
			for (int i = 0; i < STACK_DEPTH; i++) begin
				stack_val[i] = '0;
				stack_str[i] = 1'b0;
			end
			depth      = 0;
			pc         = '0;
			halt       = 1'b0;
			prog_size  = '0;
			mismatches = 0;
			pending_results.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got.next_pc   = m_tdata[15:0];
				got.halted    = m_tdata[16];
				got.printed   = m_tdata[17];
				got.print_val = m_tdata[49:18];
				got.fault     = m_tdata[52:50];
				got.print_str = m_tuser;
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result word with none expected: %p", $realtime, got);
				end else begin
					want = pending_results.pop_front();
					if (got !== want || m_tdata[55:53] !== 3'd0) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: result mismatch\n  expected %p\n  actual   %p",
								$realtime, want, got);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				run_instruction(s_tuser, s_tdata, fresh);
				pending_results.push_back(fresh);
			end
			if (cfg_we)
				prog_size = cfg_wdata;
		end
	end

endmodule

>>> test/tb_stack_bytecode_executor.sv
// Testbench top for the stack bytecode executor: program stimulus, idling and verdict
`timescale 1ns / 100ps
module tb_stack_bytecode_executor import sbe_pkg::*;;

	localparam int RANDOM_WORDS = 340;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int SETTLE       = 40;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [4:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	logic        m_tuser;
	int          mismatches;
	int          outstanding;

	// sequencer bookkeeping: depth and pc the program is expected to reach
	int          seq_depth;
	int          seq_pc;
	int          size_now;
	logic        no_gaps;
	int          cycles;

	stack_bytecode_executor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	stack_bytecode_executor_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// bound the run
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("tb_stack_bytecode_executor NOT OK");
				$finish;
			end
		end
	end

	// result side: stall a random number of cycles before each word
	initial begin : result_side
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	// send one instruction word and track depth and pc
	task automatic issue(input logic [4:0] op, input logic [31:0] arg);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= arg;
		do @(posedge clk); while (!s_tready);
		case (op)
			OP_LDI, OP_PUSH_STR, OP_LDV: begin
				seq_depth++;
				seq_pc += 2;
			end
			OP_ASSIGN, OP_JZ: begin
				seq_depth--;
				seq_pc += 2;
			end
			OP_NEG: seq_pc += 1;
			OP_JUMP: seq_pc = int'(arg);
			OP_CALL: begin
				seq_depth++;
				seq_pc = int'(arg);
			end
			OP_RET: seq_depth--;
			default: begin
				seq_depth--;
				seq_pc += 1;
			end
		endcase
	endtask

	// write program size once the block has drained
	task automatic write_size(input int value);
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= 16'(value);
		@(posedge clk);
		cfg_we    <= 1'b0;
		size_now = value;
	endtask

	// one random well-formed step that keeps the program running
	task automatic random_step();
		int pick, ret;
		logic [4:0] op;
		if (seq_pc + 8 >= size_now) begin
			issue(OP_JUMP, 32'($urandom_range(0, size_now / 2)));
			return;
		end
		pick = $urandom_range(0, 99);
		if (seq_depth >= 250)
			pick = 95;
		if (pick < 30 || seq_depth == 0) begin
			case ($urandom_range(0, 2))
				0: issue(OP_LDI, $urandom());
				1: issue(OP_PUSH_STR, $urandom());
				default: issue(OP_LDV, 32'($urandom_range(0, VAR_COUNT - 1)));
			endcase
		end else if (pick < 50 && seq_depth >= 2) begin
			op = 5'($urandom_range(OP_ADD, OP_LE));
			if (op == OP_DIV || op == OP_NEG)
				op = OP_SUB;
			issue(op, $urandom());
		end else if (pick < 57) begin
			issue(OP_LDI, ($urandom() | 32'd1) << $urandom_range(0, 31));
			issue(OP_DIV, $urandom());
		end else if (pick < 62) begin
			issue(OP_NEG, $urandom());
		end else if (pick < 70) begin
			issue(OP_ASSIGN, 32'($urandom_range(0, VAR_COUNT - 1)));
		end else if (pick < 77) begin
			issue(OP_JZ, 32'(seq_pc + 2));
		end else if (pick < 84) begin
			ret = seq_pc + 2;
			issue(OP_CALL, 32'($urandom_range(0, size_now - 10)));
			issue(OP_LDI, $urandom());
			issue(OP_EMIT, $urandom());
			issue(OP_RET, $urandom());
			seq_pc = ret;
		end else if (pick < 88) begin
			issue(OP_JUMP, 32'($urandom_range(0, size_now - 9)));
		end else begin
			issue(OP_EMIT, $urandom());
		end
	endtask

	// stimulus and verdict
	initial begin : stimulus
		int done_words, ending, sizes [4];
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		no_gaps   = 1'b0;
		seq_depth = 0;
		seq_pc    = 0;
		size_now  = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_size(65535);

		// arithmetic extremes, tags, compares, variables and control flow
		issue(OP_LDI, 32'h7fffffff);
		issue(OP_LDI, 32'h80000000);
		issue(OP_ADD, 0);
		issue(OP_LDI, 32'hffffffff);
		issue(OP_SUB, 0);
		issue(OP_LDI, 32'h12345678);
		issue(OP_MUL, 0);
		issue(OP_EMIT, 0);
		issue(OP_LDI, 32'h80000000);
		issue(OP_LDI, 32'hffffffff);
		issue(OP_DIV, 0);
		issue(OP_LDI, 32'hfffffff9);
		issue(OP_LDI, 2);
		issue(OP_DIV, 0);
		for (int op = OP_EQ; op <= OP_LE; op++) begin
			issue(OP_PUSH_STR, 32'hffffffff);
			issue(OP_LDI, 32'h00000001);
			issue(5'(op), 0);
			issue(OP_EMIT, 0);
		end
		issue(OP_NEG, 0);
		issue(OP_EMIT, 0);
		issue(OP_PUSH_STR, 32'hffffffff);
		issue(OP_EMIT, 0);
		issue(OP_LDV, 32'(VAR_COUNT - 1));
		issue(OP_EMIT, 0);
		issue(OP_PUSH_STR, 7);
		issue(OP_ASSIGN, 32'(VAR_COUNT - 1));
		issue(OP_LDV, 32'(VAR_COUNT - 1));
		issue(OP_NEG, 0);
		issue(OP_EMIT, 0);
		issue(OP_LDI, 0);
		issue(OP_JZ, 500);
		seq_pc = 500;
		issue(OP_LDI, 32'h80000000);
		issue(OP_JZ, 9999);
		issue(OP_CALL, 1000);
		issue(OP_RET, 0);
		seq_pc = 506;
		issue(OP_PUSH_STR, 50);
		issue(OP_RET, 0);
		seq_pc = 50;
		issue(OP_JUMP, 65530);
		issue(OP_JUMP, 0);
		// fill the stack to its last entry and drain it again
		while (seq_depth < STACK_DEPTH)
			issue(OP_LDI, $urandom());
		while (seq_depth > 0)
			issue(OP_EMIT, 0);

		// random programs under several program sizes
		sizes = '{300, 12, 65535, 2000};
		done_words = 0;
		foreach (sizes[i]) begin
			issue(OP_JUMP, 0);
			write_size(sizes[i]);
			while (done_words < (i + 1) * RANDOM_WORDS / 4) begin
				if (done_words % 60 == 0)
					no_gaps = ($urandom_range(0, 3) == 0);
				random_step();
				done_words++;
			end
		end
		no_gaps = 1'b0;

		// end the program in one of its halting ways
		issue(OP_JUMP, 0);
		write_size(65535);
		ending = $urandom_range(0, 8);
		case (ending)
			0: issue(5'($urandom_range(OP_EMIT + 1, 31)), $urandom());
			1: begin
				while (seq_depth > 1)
					issue(OP_EMIT, 0);
				issue(OP_ADD, 0);
			end
			2: begin
				while (seq_depth < STACK_DEPTH)
					issue(OP_LDI, $urandom());
				issue(OP_CALL, 10);
			end
			3: begin
				issue(OP_LDI, 5);
				issue(OP_LDI, 0);
				issue(OP_DIV, 0);
			end
			4: issue(OP_LDV, ($urandom_range(0, 1) == 0) ? 32'(VAR_COUNT) : 32'hffffffff);
			5: issue(OP_JUMP, ($urandom_range(0, 1) == 0) ? 32'h80000000 : 32'd65536);
			6: issue(OP_JUMP, 65535);
			7: begin
				issue(OP_LDI, 1);
				write_size(seq_pc);
			end
			default: write_size(0);
		endcase
		// everything after the halt is ignored
		repeat (6)
			issue(5'($urandom_range(0, 31)), $urandom());
		s_tvalid <= 1'b0;
		@(posedge clk);

		wait (outstanding == 0);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("tb_stack_bytecode_executor OK");
		else
			$display("tb_stack_bytecode_executor NOT OK");
		$finish;
	end

endmodule
